/* src/assert_macros.svh */
// Assertion macros used by the property checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define ASSERT_NEXT(lbl, pre, post, msg) \
	`ASSERT_CLK(lbl, (pre) |=> (post), msg)

`endif

/* src/cts_pkg.sv */
`timescale 1ns / 1ps

package cts_pkg;

	localparam logic [1:0] MODE_ADD  = 2'd0;
	localparam logic [1:0] MODE_TICK = 2'd1;
	localparam logic [1:0] MODE_DISP = 2'd2;
	localparam logic [1:0] MODE_RSVD = 2'd3;

	localparam logic [7:0] PENDING_MAX = 8'hFF;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  task_handle;
		logic [15:0] period;
		logic [15:0] delay;
	} req_t;

	typedef struct packed {
		logic [7:0] task_handle_out;
		logic [2:0] slot_index;
		logic       hit;
		logic       table_full;
		logic       last;
	} rsp_t;

	// One table entry as it is kept in the slot memory.
	typedef struct packed {
		logic [7:0]  handle;
		logic [15:0] period;
		logic [15:0] delay_left;
		logic [7:0]  pending;
	} slot_t;

	localparam int SLOT_BITS = $bits(slot_t);

endpackage

/* src/cooperative_task_scheduler.sv */
`timescale 1ns / 1ps
// Add: the answer is registered from the ADD state once the result register is free.
// Tick: the walk reads one slot memory entry per cycle.
// Dispatch: a memory read, then a write back, for each ready slot in turn.
// One item is worked on at a time; the next is taken once the block is idle again.
// Reset clears the used and ready flags at once; memory contents need no clearing.
module cooperative_task_scheduler import cts_pkg::*; #(
	parameter int TASK_SLOTS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  logic req_valid,
	output logic req_ready,
	output rsp_t rsp,
	output logic rsp_valid,
	input  logic rsp_ready
);

	localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int CW = $clog2(TASK_SLOTS + 1);
	localparam logic [CW-1:0] WALK_END = CW'(TASK_SLOTS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_TICK,
		ST_DRD,
		ST_DWB
	} state_t;

	// Lowest set bit of a slot vector, with a found flag on top.
	function automatic logic [SW:0] first_one(input logic [TASK_SLOTS-1:0] v);
		logic [SW:0] r;
		r = '0;
		for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = {1'b1, SW'(i)};
			end
		end
		return r;
	endfunction

	state_t                state_q;
	req_t                  req_q;
	logic [TASK_SLOTS-1:0] used_q;
	logic [TASK_SLOTS-1:0] ready_q;
	logic [TASK_SLOTS-1:0] rem_q;
	logic [CW-1:0]         rd_cnt_q;
	logic                  v_s1;
	logic [SW-1:0]         idx_s1;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic                  ram_we;
	logic [SW-1:0]         ram_waddr;
	slot_t                 ram_wdata;
	logic                  ram_re;
	logic [SW-1:0]         ram_raddr;
	slot_t                 ram_rdata;

	logic [SW:0]           free_sel;
	logic [SW:0]           pick_sel;
	logic                  ofree;
	logic                  walk_more;
	logic                  rsp_load;
	slot_t                 tick_word;
	slot_t                 disp_word;
	logic [TASK_SLOTS-1:0] rem_after;

	cts_ram #(
		.WIDTH(SLOT_BITS),
		.DEPTH(TASK_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign free_sel  = first_one(~used_q);
	assign pick_sel  = first_one(rem_q);
	assign ofree     = !rsp_valid_q || rsp_ready;
	assign walk_more = (rd_cnt_q != WALK_END);
	assign rem_after = rem_q & ~(TASK_SLOTS'(1) << idx_s1);

	// A new result enters the output register at this edge: an add answer,
	// the empty dispatch answer, or one dispatched slot.
	assign rsp_load = ofree && (state_q == ST_ADD || state_q == ST_DWB ||
		(state_q == ST_DRD && !pick_sel[SW]));

	// A tick on a slot: an expired delay owes one more run (saturating) and
	// reloads from the period when the task is periodic; otherwise count down.
	always_comb begin
		tick_word = ram_rdata;
		if (ram_rdata.delay_left == 16'd0) begin
			if (ram_rdata.pending != PENDING_MAX) begin
				tick_word.pending = ram_rdata.pending + 8'd1;
			end
			if (ram_rdata.period != 16'd0) begin
				tick_word.delay_left = ram_rdata.period;
			end
		end else begin
			tick_word.delay_left = ram_rdata.delay_left - 16'd1;
		end
	end

	// A dispatch consumes one owed run.  A one-shot slot is freed through
	// its used flag, so the memory word itself may keep stale contents.
	always_comb begin
		disp_word = ram_rdata;
		disp_word.pending = ram_rdata.pending - 8'd1;
	end

	// Memory port control.  Within a walk each slot is read once and written
	// at most once, and a write always lands before any later read
	// of the same entry, so no forwarding path is needed.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_s1;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = idx_s1;
		unique case (state_q)
			ST_ADD: begin
				if (ofree && free_sel[SW]) begin
					ram_we    = 1'b1;
					ram_waddr = free_sel[SW-1:0];
					ram_wdata = '{handle: req_q.task_handle, period: req_q.period,
						delay_left: req_q.delay, pending: 8'd0};
				end
			end
			ST_TICK: begin
				ram_re    = walk_more;
				ram_raddr = rd_cnt_q[SW-1:0];
				if (v_s1 && used_q[idx_s1]) begin
					ram_we    = 1'b1;
					ram_wdata = tick_word;
				end
			end
			ST_DRD: begin
				ram_re    = pick_sel[SW];
				ram_raddr = pick_sel[SW-1:0];
			end
			ST_DWB: begin
				if (ofree) begin
					ram_we    = 1'b1;
					ram_wdata = disp_word;
				end
			end
			default: begin
			end
		endcase
	end

	// Control state, flag vectors and the result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			ready_q     <= '0;
			rem_q       <= '0;
			rd_cnt_q    <= '0;
			v_s1        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						unique case (req.mode)
							MODE_ADD:  state_q <= ST_ADD;
							MODE_TICK: begin
								state_q  <= ST_TICK;
								rd_cnt_q <= '0;
								v_s1     <= 1'b0;
							end
							MODE_DISP: begin
								state_q <= ST_DRD;
								rem_q   <= used_q & ready_q;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_ADD: begin
					if (ofree) begin
						if (free_sel[SW]) begin
							used_q[free_sel[SW-1:0]]  <= 1'b1;
							ready_q[free_sel[SW-1:0]] <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_TICK: begin
					if (walk_more) begin
						rd_cnt_q <= rd_cnt_q + CW'(1);
					end
					v_s1 <= walk_more;
					if (v_s1 && used_q[idx_s1]) begin
						ready_q[idx_s1] <= (tick_word.pending != 8'd0);
					end
					if (!walk_more && !v_s1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DRD: begin
					if (pick_sel[SW]) begin
						state_q <= ST_DWB;
					end else if (ofree) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DWB: begin
					if (ofree) begin
						rem_q[idx_s1] <= 1'b0;
						if (ram_rdata.period == 16'd0) begin
							used_q[idx_s1]  <= 1'b0;
							ready_q[idx_s1] <= 1'b0;
						end else begin
							ready_q[idx_s1] <= (disp_word.pending != 8'd0);
						end
						state_q <= (rem_after == '0) ? ST_IDLE : ST_DRD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers: the held item, the slot in flight and the result.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			req_q <= req;
		end
		if (state_q == ST_TICK && walk_more) begin
			idx_s1 <= rd_cnt_q[SW-1:0];
		end
		if (state_q == ST_DRD) begin
			idx_s1 <= pick_sel[SW-1:0];
		end
		if (ofree) begin
			if (state_q == ST_ADD) begin
				if (free_sel[SW]) begin
					rsp_q <= '{task_handle_out: req_q.task_handle,
						slot_index: 3'(free_sel[SW-1:0]), hit: 1'b1,
						table_full: 1'b0, last: 1'b1};
				end else begin
					rsp_q <= '{task_handle_out: 8'd0, slot_index: 3'd0, hit: 1'b0,
						table_full: 1'b1, last: 1'b1};
				end
			end
			if (state_q == ST_DRD && !pick_sel[SW]) begin
				rsp_q <= '{task_handle_out: 8'd0, slot_index: 3'd0, hit: 1'b0,
					table_full: 1'b0, last: 1'b1};
			end
			if (state_q == ST_DWB) begin
				rsp_q <= '{task_handle_out: ram_rdata.handle, slot_index: 3'(idx_s1),
					hit: 1'b1, table_full: 1'b0, last: (rem_after == '0)};
			end
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

/* src/cts_ram.sv */
`timescale 1ns / 1ps

module cts_ram #(
	parameter  int WIDTH = 8,
	parameter  int DEPTH = 8,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [AW-1:0]            raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read data is registered and holds until the next enabled read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/cts_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cts_props import cts_pkg::*; (
	input logic clk,
	input logic arst_n,
	input req_t req,
	input logic req_valid,
	input logic req_ready,
	input rsp_t rsp,
	input logic rsp_valid,
	input logic rsp_ready
);

	`ASSERT_CLK(a_full_clean, (rsp_valid && rsp.table_full) |-> (!rsp.hit && rsp.slot_index == 3'd0 && rsp.task_handle_out == 8'd0), "table full result carries a slot")
	`ASSERT_CLK(a_miss_last, (rsp_valid && !rsp.hit) |-> rsp.last, "result without a hit is not the last")
	`ASSERT_CLK(a_full_nohit, rsp_valid |-> !(rsp.hit && rsp.table_full), "hit and table full together")
	`ASSERT_NEXT(a_busy, req_valid && req_ready && req.mode != MODE_RSVD, !req_ready, "block took a new item while busy")
	`ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "stalled result changed")

endmodule

bind cooperative_task_scheduler cts_props u_cts_props (.*);

/* verif/cts_checker.sv */
`timescale 1ns / 1ps

module cts_checker import cts_pkg::*; #(
	parameter int TASK_SLOTS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  logic req_valid,
	input  logic req_ready,
	input  rsp_t rsp,
	input  logic rsp_valid,
	input  logic rsp_ready,
	output int   mismatches,
	output int   expected_left,
	output int   results_checked,
	output int   runs_dispatched,
	output int   adds_rejected
);

	localparam int PRINT_CAP = 40;

	logic        slot_busy      [TASK_SLOTS];
	logic [7:0]  slot_handle    [TASK_SLOTS];
	logic [15:0] slot_period    [TASK_SLOTS];
	logic [15:0] slot_countdown [TASK_SLOTS];
	logic [7:0]  slot_owed      [TASK_SLOTS];
	rsp_t        owed_results   [$];

	initial begin
		mismatches = 0;
		expected_left = 0;
		results_checked = 0;
		runs_dispatched = 0;
		adds_rejected = 0;
	end

	// Only the first PRINT_CAP mismatches are printed; the rest are still counted.
	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (mismatches < PRINT_CAP)
			$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what,
				got, want);
		mismatches++;
	endtask

	task automatic clear_slot(input int s);
		slot_busy[s] = 1'b0;
		slot_handle[s] = 8'd0;
		slot_period[s] = 16'd0;
		slot_countdown[s] = 16'd0;
		slot_owed[s] = 8'd0;
	endtask

	// Updates the task table for one transfer and queues the results it owes.
	task automatic apply_request(input req_t item);
		int   s;
		int   free_slot;
		int   found;
		rsp_t held;
		held = '0;
		case (item.mode)
			MODE_ADD: begin
				free_slot = -1;
				for (s = 0; s < TASK_SLOTS; s++)
					if (!slot_busy[s] && free_slot < 0)
						free_slot = s;
				held.last = 1'b1;
				if (free_slot < 0) begin
					held.table_full = 1'b1;
					adds_rejected++;
				end else begin
					slot_busy[free_slot] = 1'b1;
					slot_handle[free_slot] = item.task_handle;
					slot_period[free_slot] = item.period;
					slot_countdown[free_slot] = item.delay;
					slot_owed[free_slot] = 8'd0;
					held.task_handle_out = item.task_handle;
					held.slot_index = free_slot[2:0];
					held.hit = 1'b1;
				end
				owed_results.push_back(held);
			end
			MODE_TICK: begin
				for (s = 0; s < TASK_SLOTS; s++) begin
					if (slot_busy[s]) begin
						if (slot_countdown[s] == 16'd0) begin
							if (slot_owed[s] != PENDING_MAX)
								slot_owed[s] = slot_owed[s] + 8'd1;
							if (slot_period[s] != 16'd0)
								slot_countdown[s] = slot_period[s];
						end else begin
							slot_countdown[s] = slot_countdown[s] - 16'd1;
						end
					end
				end
			end
			MODE_DISP: begin
				// Each result is held back one step so the final one can carry last.
				found = 0;
				for (s = 0; s < TASK_SLOTS; s++) begin
					if (slot_busy[s] && slot_owed[s] != 8'd0) begin
						if (found != 0)
							owed_results.push_back(held);
						held = '0;
						held.task_handle_out = slot_handle[s];
						held.slot_index = s[2:0];
						held.hit = 1'b1;
						found++;
						slot_owed[s] = slot_owed[s] - 8'd1;
						if (slot_period[s] == 16'd0)
							clear_slot(s);
					end
				end
				// With nothing ready, held is still all zero: the empty result.
				held.last = 1'b1;
				owed_results.push_back(held);
				runs_dispatched += found;
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_result(input rsp_t got, input rsp_t want);
		if (got.task_handle_out !== want.task_handle_out)
			report_mismatch("task_handle_out", 32'(got.task_handle_out),
				32'(want.task_handle_out));
		if (got.slot_index !== want.slot_index)
			report_mismatch("slot_index", 32'(got.slot_index), 32'(want.slot_index));
		if (got.hit !== want.hit)
			report_mismatch("hit", 32'(got.hit), 32'(want.hit));
		if (got.table_full !== want.table_full)
			report_mismatch("table_full", 32'(got.table_full), 32'(want.table_full));
		if (got.last !== want.last)
			report_mismatch("last", 32'(got.last), 32'(want.last));
		results_checked++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < TASK_SLOTS; s++)
				clear_slot(s);
			owed_results.delete();
			expected_left <= 0;
		end else begin
			// A result leaving at this edge always belongs to an earlier request.
			if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
				if (owed_results.size() == 0)
					report_mismatch("result with nothing expected", 32'(rsp), 32'd0);
				else
					check_result(rsp, owed_results.pop_front());
			end
			if (req_valid === 1'b1 && req_ready === 1'b1)
				apply_request(req);
			expected_left <= owed_results.size();
		end
	end

endmodule

/* verif/cooperative_task_scheduler_tb.sv */
`timescale 1ns / 1ps

module cooperative_task_scheduler_tb;
	import cts_pkg::*;

	localparam int TASK_SLOTS     = 8;
	// Useful random transfers (add, tick, dispatch) in the random phase.
	localparam int RANDOM_ITEMS   = 150;
	localparam int LONG_HOLD      = 400;
	// A tick walks every slot and gives no result, so allow a few walks.
	localparam int SETTLE_CYCLES  = 4 * TASK_SLOTS + 20;
	localparam int CYCLE_LIMIT    = 600000;
	// Periodic tasks are never freed, so only a few may be added at random
	// or the table would stay full for the rest of the run.
	localparam int MAX_PERIODIC   = 2;

	logic clk;
	logic arst_n     = 1'b0;
	req_t req        = '0;
	logic req_valid  = 1'b0;
	logic req_ready;
	rsp_t rsp;
	logic rsp_valid;
	logic rsp_ready  = 1'b0;
	logic hold_asked = 1'b0;

	int mismatches;
	int expected_left;
	int results_checked;
	int runs_dispatched;
	int adds_rejected;

	int burst_left     = 0;
	int periodic_added = 0;
	int cycle_count    = 0;
	int sent_per_mode [4];

	cooperative_task_scheduler #(
		.TASK_SLOTS(TASK_SLOTS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.rsp      (rsp),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready)
	);

	cts_checker #(
		.TASK_SLOTS(TASK_SLOTS)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.rsp            (rsp),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.mismatches     (mismatches),
		.expected_left  (expected_left),
		.results_checked(results_checked),
		.runs_dispatched(runs_dispatched),
		.adds_rejected  (adds_rejected)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs or a result never shows up.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycle_count, expected_left);
			$display("cooperative_task_scheduler regression: fail");
			$finish;
		end
	end

	function automatic req_t make_req(input logic [1:0] mode, input logic [7:0] handle,
		input logic [15:0] period, input logic [15:0] delay);
		req_t item;
		item.mode = mode;
		item.task_handle = handle;
		item.period = period;
		item.delay = delay;
		return item;
	endfunction

	// Tick, dispatch and the unused mode ignore the task fields, so they carry
	// random content there. That is what toggles every bit of the wide fields
	// without parking long-delay tasks in the table forever.
	function automatic req_t filler_req(input logic [1:0] mode);
		return make_req(mode, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)));
	endfunction

	// Mostly one-shot tasks with short delays, so they run and free their
	// slot soon. Now and then a periodic task, within the budget above.
	function automatic req_t random_add();
		logic [15:0] period;
		period = 16'd0;
		if (periodic_added < MAX_PERIODIC && $urandom_range(0, 9) == 0) begin
			periodic_added++;
			if ($urandom_range(0, 3) == 0)
				period = 16'($urandom_range(1, 65535));
			else
				period = 16'($urandom_range(1, 6));
		end
		return make_req(MODE_ADD, 8'($urandom_range(0, 255)), period,
			16'($urandom_range(0, 6)));
	endfunction

	// Offers one request and returns at the edge where it transfers. The
	// sender works in bursts; between bursts valid drops for a random gap,
	// and a zero gap lets two bursts run together into a longer stretch.
	task automatic offer(input req_t item);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		sent_per_mode[item.mode]++;
		req <= item;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_ready !== 1'b1);
	endtask

	// Stops offering until every predicted result has come back.
	task automatic wait_for_results();
		req_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (expected_left != 0)
			@(posedge clk);
	endtask

	// The receiver switches between stall styles in stretches of its own:
	// always ready, coin flip, mostly stalled and a fixed rhythm. Once the
	// sender asks for it, it also holds off for one long stretch.
	initial begin : receiver
		int style;
		int stretch;
		bit long_hold_done;
		style = 0;
		stretch = 0;
		long_hold_done = 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			if (hold_asked === 1'b1 && !long_hold_done) begin
				long_hold_done = 1'b1;
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				if (stretch == 0) begin
					style = $urandom_range(0, 3);
					stretch = $urandom_range(16, 96);
				end
				stretch--;
				case (style)
					0: rsp_ready <= 1'b1;
					1: rsp_ready <= 1'($urandom_range(0, 1));
					2: rsp_ready <= ($urandom_range(0, 3) == 0);
					default: rsp_ready <= (stretch % 3 != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int n;
		int k;
		int useful_sent;
		bit hold_set;
		bit paused;
		hold_set = 1'b0;
		paused = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. On an empty table a dispatch gives the empty result,
		// a tick gives nothing and the unused mode is ignored.
		offer(make_req(MODE_DISP, 8'h00, 16'h0000, 16'h0000));
		offer(make_req(MODE_TICK, 8'hFF, 16'hFFFF, 16'hFFFF));
		offer(make_req(MODE_RSVD, 8'hA5, 16'h5A5A, 16'hA5A5));
		// The highest handle with the longest period: it runs on the first
		// tick and then reloads a delay it never works off in this run.
		offer(make_req(MODE_ADD, 8'hFF, 16'hFFFF, 16'h0000));
		// Handle zero is a real task; these one-shots become ready on the first, third and second tick.
		offer(make_req(MODE_ADD, 8'h00, 16'h0000, 16'h0000));
		offer(make_req(MODE_ADD, 8'h5A, 16'h0000, 16'h0002));
		offer(make_req(MODE_ADD, 8'h33, 16'h0000, 16'h0001));
		for (k = 0; k < 4; k++)
			offer(make_req(MODE_ADD, 8'(8'h80 + k), 16'h0000, 16'h0000));
		// The table is now full, so this add is turned away untouched.
		offer(make_req(MODE_ADD, 8'hA5, 16'hFFFF, 16'hFFFF));
		// Two ticks leave several slots with pending runs, some with two.
		offer(make_req(MODE_TICK, 8'h00, 16'h0000, 16'h0000));
		offer(make_req(MODE_TICK, 8'h00, 16'h0000, 16'h0000));
		// One dispatch gives a result per ready slot and frees the ready one-shots.
		offer(make_req(MODE_DISP, 8'hFF, 16'hFFFF, 16'hFFFF));
		// The freed low slot is reused by a period-one task.
		offer(make_req(MODE_ADD, 8'hC3, 16'h0001, 16'h0000));
		offer(make_req(MODE_TICK, 8'h00, 16'h0000, 16'h0000));
		offer(make_req(MODE_DISP, 8'h00, 16'h0000, 16'h0000));
		offer(make_req(MODE_RSVD, 8'h00, 16'h0000, 16'h0000));
		offer(make_req(MODE_DISP, 8'h00, 16'h0000, 16'h0000));
		wait_for_results();

		// Random part. Most of it is a well-formed round: a few adds, a few
		// ticks, then a dispatch. The rest is noise: lone ticks or dispatches,
		// runs of adds that fill the table, and the unused mode.
		useful_sent = 0;
		while (useful_sent < RANDOM_ITEMS) begin
			// Partway in, the receiver holds off for a long stretch while
			// the sender keeps going, so the block fills and stalls its input.
			if (!hold_set && useful_sent >= 60) begin
				hold_set = 1'b1;
				hold_asked <= 1'b1;
			end
			// Later on, the sender waits for every result once.
			if (!paused && useful_sent >= 120) begin
				paused = 1'b1;
				wait_for_results();
			end
			if ($urandom_range(0, 9) < 7) begin
				n = $urandom_range(1, 3);
				repeat (n) offer(random_add());
				useful_sent += n;
				n = $urandom_range(0, 6);
				repeat (n) offer(filler_req(MODE_TICK));
				useful_sent += n;
				offer(filler_req(MODE_DISP));
				useful_sent++;
			end else begin
				case ($urandom_range(0, 3))
					0: offer(filler_req(MODE_RSVD));
					1: begin
						offer(filler_req(MODE_DISP));
						useful_sent++;
					end
					2: begin
						offer(filler_req(MODE_TICK));
						useful_sent++;
					end
					default: begin
						n = $urandom_range(2, 5);
						repeat (n) offer(random_add());
						useful_sent += n;
					end
				endcase
			end
		end

		// Let the last tick walk finish and catch any stray result.
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d adds, %0d ticks, %0d dispatches and %0d unused-mode items; %0d results checked.",
			sent_per_mode[MODE_ADD], sent_per_mode[MODE_TICK], sent_per_mode[MODE_DISP],
			sent_per_mode[MODE_RSVD], results_checked);
		$display("%0d task runs dispatched, %0d adds refused by a full table,",
			runs_dispatched, adds_rejected);
		if (mismatches == 0)
			$display("cooperative_task_scheduler regression: pass");
		else
			$display("cooperative_task_scheduler regression: fail");
		$finish;
	end

endmodule

/* sim.f */
+incdir+src
src/cts_pkg.sv
src/cts_ram.sv
src/cooperative_task_scheduler.sv
src/cts_checker.sv
verif/cts_checker.sv
verif/cooperative_task_scheduler_tb.sv
